FILE: sv/ssh_pkg.sv
// Shared types and constants for the SuperFastHash streaming block.
// Used by the front end, the command queue, the back end and the top level; no dependencies.
package ssh_pkg;

    localparam int LEN_WIDTH_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One command from the front end to the back end.
    // A command is sent for every completed four-byte group and for the byte
    // that ends a message. The first command of a message carries the seed.
    typedef struct packed {
        logic        first;     // load the running hash from seed first
        logic [15:0] seed;      // message length, already masked
        logic        mix;       // mix one four-byte group
        logic [15:0] lo16;      // first two bytes of the group, little-endian
        logic [15:0] hi16;      // last two bytes of the group, little-endian
        logic        fin;       // finish the message after this command
        logic [23:0] tail;      // remainder bytes, first byte lowest
        logic [1:0]  tail_cnt;  // number of remainder bytes
    } t_cmd;

endpackage

FILE: sv/ssh_front.sv
// Front end of the SuperFastHash block: accepts bytes and gathers groups.
// Turns the byte stream into ssh_pkg::t_cmd commands for the queue.
module ssh_front #(
    parameter int LEN_WIDTH = ssh_pkg::LEN_WIDTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic [15:0]   i_msg_length,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output ssh_pkg::t_cmd o_cmd
);

    localparam logic [15:0] LEN_MASK = (LEN_WIDTH >= 16) ? 16'hFFFF :
                                       16'((32'd1 << LEN_WIDTH) - 32'd1);

    logic        r_in_msg, n_in_msg;
    logic        r_sent, n_sent;
    logic [15:0] r_seed, n_seed;
    logic [23:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;

    logic        accept;
    logic        need_push;
    logic [15:0] len;
    logic [15:0] seed_cur;
    logic        sent_cur;
    logic [23:0] pend_cur;
    logic [1:0]  cnt_cur;
    logic [23:0] pend_new;
    logic [1:0]  cnt_new;
    logic        do_mix;

    assign o_ready = i_cmd_ready;
    assign accept  = i_valid && i_cmd_ready;
    assign len     = i_msg_length & LEN_MASK;

    always_comb begin
        seed_cur = r_in_msg ? r_seed : len;
        sent_cur = r_in_msg ? r_sent : 1'b0;
        pend_cur = r_in_msg ? r_pend : 24'd0;
        cnt_cur  = r_in_msg ? r_cnt  : 2'd0;

        do_mix   = (cnt_cur == 2'd3);
        pend_new = 24'd0;
        cnt_new  = 2'd0;
        if (!do_mix) begin
            pend_new = pend_cur | (24'(i_data_byte) << {cnt_cur, 3'b000});
            cnt_new  = cnt_cur + 2'd1;
        end

        o_cmd.first    = !sent_cur;
        o_cmd.seed     = seed_cur;
        o_cmd.mix      = do_mix;
        o_cmd.lo16     = pend_cur[15:0];
        o_cmd.hi16     = {i_data_byte, pend_cur[23:16]};
        o_cmd.fin      = i_last;
        o_cmd.tail     = pend_new;
        o_cmd.tail_cnt = cnt_new;
        need_push      = do_mix || i_last;

        n_in_msg = r_in_msg;
        n_sent   = r_sent;
        n_seed   = r_seed;
        n_pend   = r_pend;
        n_cnt    = r_cnt;

        if (!r_in_msg && len == 16'd0) begin
            // Empty message: seed of zero, finished at once with no tail.
            o_cmd.first    = 1'b1;
            o_cmd.seed     = 16'd0;
            o_cmd.mix      = 1'b0;
            o_cmd.fin      = 1'b1;
            o_cmd.tail     = 24'd0;
            o_cmd.tail_cnt = 2'd0;
            need_push      = 1'b1;
        end else if (accept) begin
            n_in_msg = !i_last;
            n_sent   = sent_cur || need_push;
            n_seed   = seed_cur;
            n_pend   = pend_new;
            n_cnt    = cnt_new;
        end
    end

    assign o_cmd_valid = i_valid && need_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_sent   <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_in_msg <= n_in_msg;
            r_sent   <= n_sent;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
        r_pend <= n_pend;
    end

endmodule

FILE: sv/ssh_queue.sv
// Short register FIFO of ssh_pkg::t_cmd commands between front and back end.
// Depends on ssh_pkg for the command type.
module ssh_queue #(
    parameter int DEPTH = ssh_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ssh_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ssh_pkg::t_cmd o_pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ssh_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: sv/ssh_back.sv
// Back end of the SuperFastHash block: running hash, tail and avalanche.
// Pops ssh_pkg::t_cmd commands and drives the registered result stream.
module ssh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  ssh_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_hash
);

    function automatic logic [31:0] mix_group(logic [31:0] h_in, logic [15:0] lo,
                                              logic [15:0] hi);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, lo};
        t = ({16'd0, hi} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] sext8(logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] mix_tail(logic [31:0] h_in, logic [23:0] tail,
                                             logic [1:0] cnt);
        logic [31:0] h;
        h = h_in;
        case (cnt)
            2'd3: begin
                h = h + {16'd0, tail[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext8(tail[23:16]) << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'd0, tail[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + sext8(tail[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic logic [31:0] aval_step(logic [31:0] h_in, int sl, int sr);
        logic [31:0] h;
        h = h_in ^ (h_in << sl);
        h = h + (h >> sr);
        return h;
    endfunction

    logic        en;
    logic        pop;
    logic [31:0] h_start, h_mixed;

    logic [31:0] r_hash;
    logic        r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic [31:0] r_s1_h, r_s2_h, r_s3_h, r_s4_h, r_out_h;
    logic [23:0] r_s1_tail;
    logic [1:0]  r_s1_cnt;

    // The whole finishing pipeline moves together; it holds only while the
    // output register is full and not taken.
    assign en          = !r_out_v || i_ready;
    assign o_cmd_ready = en;
    assign pop         = en && i_cmd_valid;

    assign h_start = i_cmd.first ? {16'd0, i_cmd.seed} : r_hash;
    assign h_mixed = i_cmd.mix ? mix_group(h_start, i_cmd.lo16, i_cmd.hi16) : h_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= pop && i_cmd.fin;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_out_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_cmd.fin) begin
            r_hash <= h_mixed;
        end
        if (en) begin
            r_s1_h    <= h_mixed;
            r_s1_tail <= i_cmd.tail;
            r_s1_cnt  <= i_cmd.tail_cnt;
            r_s2_h    <= mix_tail(r_s1_h, r_s1_tail, r_s1_cnt);
            r_s3_h    <= aval_step(r_s2_h, 3, 5);
            r_s4_h    <= aval_step(r_s3_h, 4, 17);
            r_out_h   <= aval_step(r_s4_h, 25, 6);
        end
    end

    assign o_valid = r_out_v;
    assign o_hash  = r_out_h;

endmodule

FILE: sv/superfast_string_hash.sv
// Top level of the streaming SuperFastHash block.
// Instantiates ssh_front, ssh_queue and ssh_back; types come from ssh_pkg.
//
// Usage:
//   Slave side: one byte of the string per request. tdata carries the byte
//   in bits 7..0 and the total message length in bits 23..8; the length is
//   sampled on the first byte of a message only. tlast marks the final byte.
//   A first request whose length is zero stands for the empty string: its
//   byte is ignored and a hash of 0 is returned for it.
//   Master side: one 32-bit hash per message in tdata, after its last byte.
//
// Throughput is one byte per cycle, sustained, also for back-to-back short
// messages, while the result stream is not stalled: the running hash takes
// one command per cycle from the queue. The command is written to the queue
// at the edge that accepts the last byte; then come the group and seed mix,
// the tail mix and the avalanche in three registered steps, the last of
// which is the output register.
//
// Reset clears the message state, the queue and the output valid; the next
// byte accepted starts a new message. When the receiver holds tready low the
// result stays in the output register and the finishing pipeline halts;
// bytes are still accepted until the command queue of QUEUE_DEPTH entries
// is full, and only then does o_s_tready drop.
module superfast_string_hash #(
    parameter int LEN_WIDTH   = ssh_pkg::LEN_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = ssh_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] data_byte, [23:8] msg_length
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] hash_value
);

    ssh_pkg::t_cmd front_cmd;
    ssh_pkg::t_cmd back_cmd;
    logic          front_valid, front_ready;
    logic          back_valid, back_ready;

    ssh_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data_byte  (i_s_tdata[7:0]),
        .i_last       (i_s_tlast),
        .i_msg_length (i_s_tdata[23:8]),
        .o_cmd_valid  (front_valid),
        .i_cmd_ready  (front_ready),
        .o_cmd        (front_cmd)
    );

    ssh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    ssh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_hash      (o_m_tdata)
    );

endmodule

FILE: sv/ssh_checker.sv
// Port-level assertions for superfast_string_hash, attached by bind.
// Depends only on the top level's ports.
module ssh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [23:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // The command queue can only fill up while the receiver holds a result.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // An offered request carries known fields.
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid |-> !$isunknown({i_s_tdata, i_s_tlast}))
        else $error("request fields unknown while offered");

endmodule

bind superfast_string_hash ssh_checker u_ssh_checker (.*);
